FILE: design/irp_pkg.sv
`default_nettype none

package irp_pkg;

  localparam int TEMP_FRAC_BITS = 6;
  localparam int COUNT_BITS     = 24;
  localparam int SUM_BITS       = 40;

  localparam int TEMP_W  = 15;
  localparam int DIFF_W  = TEMP_W + 1;
  localparam int CMP_W   = 18;
  localparam int COEF_W  = 28;
  localparam int COEF_FRAC = 16;
  localparam int PROD_W  = COEF_W + DIFF_W;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SHIFT   = COEF_FRAC + 2 * TEMP_FRAC_BITS;
  localparam int ACC_W   = 40 + 2 * TEMP_FRAC_BITS;
  localparam int X10_W   = ACC_W + 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // d window, kelvin scaled by 2^F
  localparam logic signed [CMP_W-1:0] D_LO = -$signed(CMP_W'(20 << TEMP_FRAC_BITS));
  localparam logic signed [CMP_W-1:0] D_HI = $signed(CMP_W'(100 << TEMP_FRAC_BITS));

  // acceptance limits at 2^-SHIFT resolution
  localparam logic signed [ACC_W-1:0] STR_TOP = $signed(ACC_W'(64'd100 << SHIFT));
  localparam logic signed [ACC_W-1:0] DEP_TOP = $signed(ACC_W'(64'd2000 << SHIFT));

  localparam logic [9:0]  MIN_STR_INIT = 10'd1000;
  localparam logic [16:0] MIN_DEP_INIT = 17'd100000;

  localparam logic signed [10:0] STR_NONE = -11'sd10;
  localparam logic signed [15:0] DEP_NONE = -16'sd10;

  localparam int SET_STR = 0;
  localparam int SET_DEP = 1;

  // [hemisphere][strength/depth][term], scaled by 2^16
  localparam logic signed [COEF_W-1:0] COEF [2][2][5] = '{
    '{ '{ 28'sd1546650,   28'sd83886,   -28'sd171049,  -28'sd3867,   28'sd2294  },
       '{ 28'sd118390784, 28'sd2221670, 28'sd6796083,  -28'sd380109, 28'sd13107 } },
    '{ '{ 28'sd2110259,   28'sd55050,   -28'sd303432,  -28'sd5308,   28'sd1376  },
       '{ 28'sd47205581,  28'sd2890138, -28'sd8749056, -28'sd29491,  28'sd83231 } }
  };

  typedef struct packed {
    logic              restart_stats;
    logic [7:0]        cloud_mask;
    logic [TEMP_W-1:0] temp_11um;
    logic [TEMP_W-1:0] temp_12um;
    logic [TEMP_W-1:0] temp_7um;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] strength_tenths;
    logic signed [15:0] depth_tenths;
    logic               pixel_good;
    logic [23:0]        good_total;
    logic [9:0]         strength_low;
    logic [9:0]         strength_high;
    logic [16:0]        depth_low;
    logic [14:0]        depth_high;
    logic [39:0]        strength_total;
    logic [39:0]        depth_total;
  } out_item_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic                     restart;
    logic                     try_it;
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] e;
    logic [TEMP_W-1:0]        t11;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

FILE: design/irp_front.sv
`default_nettype none

module irp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire irp_pkg::in_item_t  in_data,
  output logic                    q_push,
  output irp_pkg::q_entry_t       q_data,
  input  wire irp_pkg::q_status_t q_stat
);
  import irp_pkg::*;

  logic     hold_r, hold_nxt;
  q_entry_t ent_r, ent_nxt;
  q_entry_t cls;
  logic     accept;
  logic signed [CMP_W-1:0] d_ext;

  assign in_stall = hold_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_r && !q_stat.full;
  assign q_data   = ent_r;

  always_comb begin
    cls.restart = in_data.restart_stats;
    cls.t11     = in_data.temp_11um;
    cls.d = $signed({1'b0, in_data.temp_7um}) - $signed({1'b0, in_data.temp_11um});
    cls.e = $signed({1'b0, in_data.temp_11um}) - $signed({1'b0, in_data.temp_12um});
    d_ext = CMP_W'(cls.d);
    cls.try_it = (in_data.cloud_mask > 8'd1) && (d_ext >= D_LO) && (d_ext <= D_HI);
  end

  always_comb begin
    hold_nxt = hold_r;
    ent_nxt  = ent_r;
    if (accept) begin
      hold_nxt = 1'b1;
      ent_nxt  = cls;
    end else if (q_push) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

FILE: design/irp_queue.sv
`default_nettype none

module irp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire irp_pkg::q_entry_t push_data,
  input  wire logic              pop,
  output irp_pkg::q_entry_t      pop_data,
  output irp_pkg::q_status_t     stat
);
  import irp_pkg::*;

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |=> (rp_r == $past(rp_r)))
    else $error("read pointer moved on empty queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

FILE: design/irp_back.sv
`default_nettype none

module irp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_data,
  input  wire irp_pkg::q_status_t q_stat,
  input  wire irp_pkg::q_entry_t  q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output irp_pkg::out_item_t      out_data
);
  import irp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PART = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  logic     hemi_r;
  q_entry_t ent_r;

  logic signed [PROD_W-1:0] p1_r [2];
  logic signed [PROD_W-1:0] p2_r [2];
  logic signed [PROD_W-1:0] p3_r [2];
  logic signed [SQ_W-1:0]   dd_r;
  logic signed [ACC_W-1:0]  part_r [2];
  logic signed [ACC_W-1:0]  p4_r [2];
  logic signed [ACC_W-1:0]  acc_r [2];

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [9:0]            smin_r, smin_nxt, smax_r, smax_nxt;
  logic [16:0]           dmin_r, dmin_nxt;
  logic [14:0]           dmax_r, dmax_nxt;
  logic [SUM_BITS-1:0]   ssum_r, ssum_nxt, dsum_r, dsum_nxt;

  logic      ovalid_r, ovalid_nxt;
  out_item_t odata_r, odata_nxt;

  logic signed [X10_W-1:0] sx10, dx10;
  logic [9:0]            st10;
  logic [14:0]           dp10;
  logic                  good;
  logic                  commit;
  logic [COUNT_BITS-1:0] cnt_b;
  logic [9:0]            smin_b, smax_b;
  logic [16:0]           dmin_b;
  logic [14:0]           dmax_b;
  logic [SUM_BITS-1:0]   ssum_b, dsum_b;
  logic [COUNT_BITS:0]   cnt_w;
  logic [SUM_BITS:0]     ssum_w, dsum_w;

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign commit    = (state_r == S_DONE) && (!ovalid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_stat.empty) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PART;
      S_PART:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_DONE;
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // acceptance and scaling to tenths; values are positive so the shift truncates
  always_comb begin
    sx10 = (X10_W'(acc_r[SET_STR]) <<< 3) + (X10_W'(acc_r[SET_STR]) <<< 1);
    dx10 = (X10_W'(acc_r[SET_DEP]) <<< 3) + (X10_W'(acc_r[SET_DEP]) <<< 1);
    st10 = sx10[SHIFT+9:SHIFT];
    dp10 = dx10[SHIFT+14:SHIFT];
    good = ent_r.try_it
        && (acc_r[SET_STR] > ACC_W'(0)) && (acc_r[SET_STR] < STR_TOP)
        && (acc_r[SET_DEP] > ACC_W'(0)) && (acc_r[SET_DEP] < DEP_TOP);
  end

  always_comb begin
    if (ent_r.restart) begin
      cnt_b  = '0;
      smin_b = MIN_STR_INIT;
      smax_b = '0;
      dmin_b = MIN_DEP_INIT;
      dmax_b = '0;
      ssum_b = '0;
      dsum_b = '0;
    end else begin
      cnt_b  = cnt_r;
      smin_b = smin_r;
      smax_b = smax_r;
      dmin_b = dmin_r;
      dmax_b = dmax_r;
      ssum_b = ssum_r;
      dsum_b = dsum_r;
    end
    cnt_w  = {1'b0, cnt_b} + (COUNT_BITS+1)'(1);
    ssum_w = {1'b0, ssum_b} + (SUM_BITS+1)'(st10);
    dsum_w = {1'b0, dsum_b} + (SUM_BITS+1)'(dp10);

    cnt_nxt  = cnt_r;
    smin_nxt = smin_r;
    smax_nxt = smax_r;
    dmin_nxt = dmin_r;
    dmax_nxt = dmax_r;
    ssum_nxt = ssum_r;
    dsum_nxt = dsum_r;
    if (commit) begin
      cnt_nxt  = cnt_b;
      smin_nxt = smin_b;
      smax_nxt = smax_b;
      dmin_nxt = dmin_b;
      dmax_nxt = dmax_b;
      ssum_nxt = ssum_b;
      dsum_nxt = dsum_b;
      if (good) begin
        cnt_nxt  = cnt_w[COUNT_BITS] ? '1 : cnt_w[COUNT_BITS-1:0];
        smin_nxt = (st10 < smin_b) ? st10 : smin_b;
        smax_nxt = (st10 > smax_b) ? st10 : smax_b;
        dmin_nxt = (17'(dp10) < dmin_b) ? 17'(dp10) : dmin_b;
        dmax_nxt = (dp10 > dmax_b) ? dp10 : dmax_b;
        ssum_nxt = ssum_w[SUM_BITS] ? '1 : ssum_w[SUM_BITS-1:0];
        dsum_nxt = dsum_w[SUM_BITS] ? '1 : dsum_w[SUM_BITS-1:0];
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (commit) begin
      ovalid_nxt                = 1'b1;
      odata_nxt.strength_tenths = good ? $signed(11'(st10)) : STR_NONE;
      odata_nxt.depth_tenths    = good ? $signed(16'(dp10)) : DEP_NONE;
      odata_nxt.pixel_good      = good;
      odata_nxt.good_total      = 24'(cnt_nxt);
      odata_nxt.strength_low    = smin_nxt;
      odata_nxt.strength_high   = smax_nxt;
      odata_nxt.depth_low       = dmin_nxt;
      odata_nxt.depth_high      = dmax_nxt;
      odata_nxt.strength_total  = 40'(ssum_nxt);
      odata_nxt.depth_total     = 40'(dsum_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hemi_r   <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      smin_r   <= MIN_STR_INIT;
      smax_r   <= '0;
      dmin_r   <= MIN_DEP_INIT;
      dmax_r   <= '0;
      ssum_r   <= '0;
      dsum_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
      smin_r   <= smin_nxt;
      smax_r   <= smax_nxt;
      dmin_r   <= dmin_nxt;
      dmax_r   <= dmax_nxt;
      ssum_r   <= ssum_nxt;
      dsum_r   <= dsum_nxt;
      if (cfg_valid) begin
        hemi_r <= cfg_data;
      end
    end
    odata_r <= odata_nxt;
    if (q_pop) begin
      ent_r <= q_data;
    end
    // linear terms and d squared
    if (state_r == S_MUL) begin
      for (int k = 0; k < 2; k++) begin
        p1_r[k] <= COEF[hemi_r][k][1] * ent_r.d;
        p2_r[k] <= COEF[hemi_r][k][2] * ent_r.e;
        p3_r[k] <= COEF[hemi_r][k][3] * $signed({1'b0, ent_r.t11});
      end
      dd_r <= ent_r.d * ent_r.d;
    end
    if (state_r == S_PART) begin
      for (int k = 0; k < 2; k++) begin
        part_r[k] <= (ACC_W'(p1_r[k] + p2_r[k] + p3_r[k]) <<< TEMP_FRAC_BITS)
                   + (ACC_W'(COEF[hemi_r][k][0]) <<< (2 * TEMP_FRAC_BITS));
        p4_r[k]   <= ACC_W'(COEF[hemi_r][k][4] * dd_r);
      end
    end
    if (state_r == S_ACC) begin
      for (int k = 0; k < 2; k++) begin
        acc_r[k] <= part_r[k] + p4_r[k];
      end
    end
  end

  a_miss_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !odata_r.pixel_good) |->
      (odata_r.strength_tenths == STR_NONE && odata_r.depth_tenths == DEP_NONE))
    else $error("rejected pixel carries a value");

  a_good_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && odata_r.pixel_good) |->
      ($signed({1'b0, odata_r.strength_low}) <= 12'(odata_r.strength_tenths)
       && $signed({1'b0, odata_r.strength_high}) >= 12'(odata_r.strength_tenths)
       && odata_r.good_total != '0))
    else $error("accepted pixel outside its own statistics");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !ent_r.restart) |-> (cnt_nxt >= cnt_r))
    else $error("good count went down without restart");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MUL))
    else $error("pop without starting work");

endmodule

`default_nettype wire

FILE: design/inversion_retrieval_pixel_core.sv
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   irp_pkg::in_item_t  (one pixel)
// out_      output     out_valid / out_stall irp_pkg::out_item_t (one result)
// cfg_      input      cfg_valid / cfg_ready cfg_data (hemisphere select)
//
// One result per pixel. A pixel passes from acceptance to the output register
// through the front register, the queue, then the multiply, partial-sum,
// accumulate and done steps of the back end; the back end handles one pixel at a
// time and takes the next from the queue only after the last result is committed.
// rst_n is synchronous; it clears the statistics and the hemisphere select.
// The 4-entry queue keeps accepting pixels while a result waits on out_stall.

module inversion_retrieval_pixel_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire irp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output irp_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);
  import irp_pkg::*;

  logic      q_push, q_pop;
  q_entry_t  q_wdata, q_rdata;
  q_status_t q_stat;

  assign cfg_ready = 1'b1;

  irp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_stat   (q_stat)
  );

  irp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  irp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
